[hdl/rc4sc_pkg.sv]
// ----------------------------------------------------------------------------
// rc4sc_pkg
// Shared constants and types of the RC4 stream cipher unit: byte and table
// sizes, command codes and the write beat of the permutation memory.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

  localparam int BYTE_W      = 8;
  localparam int PERM_DEPTH  = 256;
  localparam int KEY_MAX_DEF = 256;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic  en;
    byte_t addr;
    byte_t data;
  } perm_wr_t;

endpackage

[hdl/rc4sc_perm_mem.sv]
// ----------------------------------------------------------------------------
// rc4sc_perm_mem
// 256-entry permutation memory, one write and one read per cycle, read data
// registered. A per-entry valid bit makes unwritten entries read as
// their own index, so a clear restores the identity permutation at once.
// A read of the entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module rc4sc_perm_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  rc4sc_pkg::perm_wr_t wr,
  input  rc4sc_pkg::byte_t    rd_addr,
  output rc4sc_pkg::byte_t    rd_data
);

  rc4sc_pkg::byte_t                     mem [rc4sc_pkg::PERM_DEPTH];
  logic [rc4sc_pkg::PERM_DEPTH-1:0]     valid_r;
  rc4sc_pkg::byte_t                     mem_q_r;
  rc4sc_pkg::byte_t                     rd_addr_r;
  logic                                 vld_q_r;
  logic                                 hit_r;
  rc4sc_pkg::byte_t                     hit_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q_r    <= mem[rd_addr];
    rd_addr_r  <= rd_addr;
    hit_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      // clear wins over a write in the same cycle
      if (clr) begin
        valid_r <= '0;
      end else if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      vld_q_r <= valid_r[rd_addr];
      hit_r   <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = hit_r   ? hit_data_r :
                   vld_q_r ? mem_q_r    : rd_addr_r;

endmodule

[hdl/rc4sc_key_mem.sv]
// ----------------------------------------------------------------------------
// rc4sc_key_mem
// Key byte store: one write and one read per cycle, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module rc4sc_key_mem #(
  parameter int DEPTH = rc4sc_pkg::KEY_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  rc4sc_pkg::byte_t                  wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output rc4sc_pkg::byte_t                  rd_data
);

  rc4sc_pkg::byte_t mem [DEPTH];
  rc4sc_pkg::byte_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule

[hdl/rc4_stream_cipher_unit.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit
// RC4 engine with key store, key schedule and keystream generator.
//
// Input channel (in_valid / in_stall): in_command selects a key byte or a
// data byte in in_byte_value; in_last_key on a key byte starts the key
// schedule. Key bytes past KEY_MAX are dropped, but their last flag counts.
// Output channel (out_valid / out_stall): one out_result_byte per data beat,
// data XOR keystream. Key beats give nothing on the output.
// A data beat runs through ST_J, ST_T and ST_OUT: read S[i], read S[j],
// read S[S[i]+S[j]] through the single read port of the permutation memory,
// with the second swap write overlapped with the next accepted beat. The
// result is registered in the output register from ST_OUT, or from ST_WAIT
// if the receiver stalls. The key schedule runs ST_KRD, then ST_KJ, ST_KW1
// and ST_KW2 per swap step, during which the input is stalled.
// Reset (synchronous, rst_n low) restores the identity permutation through
// the memory valid bits at once, zeroes both indices and the key length.
// While the receiver stalls, the output register holds its beat; one more
// finished result waits inside, and then the input stalls too.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit #(
  parameter int KEY_MAX = rc4sc_pkg::KEY_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  rc4sc_pkg::byte_t       in_byte_value,
  input  logic                   in_last_key,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rc4sc_pkg::byte_t       out_result_byte
);

  localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int LEN_W  = $clog2(KEY_MAX + 1);
  localparam rc4sc_pkg::byte_t LAST_N = rc4sc_pkg::byte_t'(rc4sc_pkg::PERM_DEPTH - 1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_J    = 9'b000000010,
    ST_T    = 9'b000000100,
    ST_OUT  = 9'b000001000,
    ST_WAIT = 9'b000010000,
    ST_KRD  = 9'b000100000,
    ST_KJ   = 9'b001000000,
    ST_KW1  = 9'b010000000,
    ST_KW2  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  rc4sc_pkg::byte_t    i_r, i_nxt;
  rc4sc_pkg::byte_t    j_r, j_nxt;
  rc4sc_pkg::byte_t    x_r, x_nxt;
  rc4sc_pkg::byte_t    t_r, t_nxt;
  rc4sc_pkg::byte_t    acc_r, acc_nxt;
  rc4sc_pkg::byte_t    n_r, n_nxt;
  logic [KIDX_W-1:0]   k_r, k_nxt;
  logic [LEN_W-1:0]    key_len_r, key_len_nxt;
  rc4sc_pkg::byte_t    value_r, value_nxt;
  rc4sc_pkg::byte_t    res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  rc4sc_pkg::byte_t    out_byte_r, out_byte_nxt;

  rc4sc_pkg::perm_wr_t perm_wr;
  logic                perm_clr;
  rc4sc_pkg::byte_t    perm_rd_addr;
  rc4sc_pkg::byte_t    perm_rd_data;
  logic                key_wr_en;
  logic [KIDX_W-1:0]   key_rd_addr;
  rc4sc_pkg::byte_t    key_rd_data;

  logic                in_accept;
  logic                out_free;
  logic [KIDX_W-1:0]   k_step;
  rc4sc_pkg::byte_t    acc_sum;
  rc4sc_pkg::byte_t    ks_byte;
  rc4sc_pkg::byte_t    res_now;

  rc4sc_perm_mem u_perm (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (perm_clr),
    .wr      (perm_wr),
    .rd_addr (perm_rd_addr),
    .rd_data (perm_rd_data)
  );

  rc4sc_key_mem #(
    .DEPTH (KEY_MAX)
  ) u_key (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_len_r[KIDX_W-1:0]),
    .wr_data (in_byte_value),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) ||
                       (((state_r == ST_OUT) || (state_r == ST_WAIT)) && out_free));
  assign in_accept = in_valid && !in_stall;

  // key index wraps over the loaded length
  assign k_step  = ((LEN_W'(k_r) + LEN_W'(1)) >= key_len_r) ? '0 : k_r + KIDX_W'(1);
  assign acc_sum = acc_r + perm_rd_data + key_rd_data;
  // S[j] is rewritten only after the keystream read was issued: forward it
  assign ks_byte = (t_r == j_r) ? x_r : perm_rd_data;
  assign res_now = value_r ^ ks_byte;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    key_len_nxt   = key_len_r;
    value_nxt     = value_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    perm_rd_addr  = i_r + 8'd1;
    perm_wr       = '0;
    perm_clr      = 1'b0;
    key_wr_en     = 1'b0;
    key_rd_addr   = k_r;

    unique case (state_r)
      ST_J: begin
        x_nxt        = perm_rd_data;
        j_nxt        = j_r + perm_rd_data;
        perm_rd_addr = j_r + perm_rd_data;
        state_nxt    = ST_T;
      end
      ST_T: begin
        t_nxt        = x_r + perm_rd_data;
        perm_rd_addr = x_r + perm_rd_data;
        perm_wr      = '{en: 1'b1, addr: i_r, data: perm_rd_data};
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        perm_wr = '{en: 1'b1, addr: j_r, data: x_r};
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_now;
          state_nxt     = ST_IDLE;
        end else begin
          res_nxt   = res_now;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_KRD: begin
        perm_rd_addr = n_r;
        key_rd_addr  = k_r;
        state_nxt    = ST_KJ;
      end
      ST_KJ: begin
        x_nxt        = perm_rd_data;
        acc_nxt      = acc_sum;
        perm_rd_addr = acc_sum;
        state_nxt    = ST_KW1;
      end
      ST_KW1: begin
        perm_wr   = '{en: 1'b1, addr: n_r, data: perm_rd_data};
        state_nxt = ST_KW2;
      end
      ST_KW2: begin
        // finish the swap and start the next step's reads
        perm_wr      = '{en: 1'b1, addr: acc_r, data: x_r};
        n_nxt        = n_r + 8'd1;
        k_nxt        = k_step;
        perm_rd_addr = n_r + 8'd1;
        key_rd_addr  = k_step;
        if (n_r == LAST_N) begin
          i_nxt       = '0;
          j_nxt       = '0;
          key_len_nxt = '0;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_KJ;
        end
      end
      default: begin
      end
    endcase

    if (in_accept) begin
      value_nxt = in_byte_value;
      if (in_command == rc4sc_pkg::CMD_DATA) begin
        i_nxt        = i_r + 8'd1;
        perm_rd_addr = i_r + 8'd1;
        state_nxt    = ST_J;
      end else begin
        // drop key bytes beyond the store
        if (key_len_r < LEN_W'(KEY_MAX)) begin
          key_wr_en   = 1'b1;
          key_len_nxt = key_len_r + LEN_W'(1);
        end
        if (in_last_key) begin
          perm_clr  = 1'b1;
          n_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_KRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      k_r         <= '0;
      key_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      key_len_r   <= key_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    acc_r      <= acc_nxt;
    value_r    <= value_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_byte = out_byte_r;

  a_key_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_len_r <= LEN_W'(KEY_MAX))
    else $error("key length beyond key store");

  a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KW2 && n_r == LAST_N) |=>
      (state_r == ST_IDLE && i_r == '0 && j_r == '0 && key_len_r == '0))
    else $error("key schedule did not finish cleanly");

  a_sched_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == rc4sc_pkg::CMD_KEY && in_last_key) |=>
      (state_r == ST_KRD && n_r == '0 && k_r == '0))
    else $error("last key beat did not start the schedule");

  a_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && out_stall) |=>
      (state_r == ST_WAIT && out_valid_r))
    else $error("result lost while output stalled");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_OUT && state_r != ST_WAIT) |-> in_stall)
    else $error("input taken while busy");

endmodule
